>>> design/gmts_pkg.sv
`default_nettype none
package gmts_pkg;

   localparam int PROC_BITS = 4;
   localparam int POLICY_BITS = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 64;
   localparam int MASK_BITS = 8;
   localparam int MISSED_BITS = 3;
   localparam int ENTRY_BITS = 8;

   localparam logic [POLICY_BITS-1:0] POLICY_EDF = 2'd0;
   localparam logic [POLICY_BITS-1:0] POLICY_FP  = 2'd1;
   localparam logic [POLICY_BITS-1:0] POLICY_LL  = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_PROCESSOR_COUNT = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_POLICY          = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WCET_TABLE      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PERIOD_TABLE    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DEADLINE_TABLE  = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LOAD   = 4'b0010,
      ST_SHIFT  = 4'b0100,
      ST_UPDATE = 4'b1000
   } state_type;

   typedef struct packed {
      logic                   accept;
      logic                   load;
      logic                   shift;
      logic                   update;
      logic [POLICY_BITS-1:0] policy;
      logic [PROC_BITS-1:0]   procs;
   } ctl_type;

endpackage
`default_nettype wire

>>> design/global_multiprocessor_task_scheduler_top.sv
`default_nettype none
// channel  direction  handshake          payload
// req      in         req_valid/stall    req_release_mask
// rsp      out        rsp_valid/stall    rsp_run_mask, rsp_deadline_miss, rsp_missed_task
// csr      in         csr_valid/ready    csr_index, csr_data
// a word steps through accept, key load, TASKS - 1 ring shifts, update
// the ring of task cells passes each rank key one cell per cycle to build the ranks
// one word in flight; the next word is taken once the update is done
// update waits while a previous result is stalled on rsp
// reset clears each task's work and period timer and loads the register defaults
module global_multiprocessor_task_scheduler_top #(
   parameter int TASKS = 8,
   parameter int TIME_BITS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_release_mask,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_run_mask,
   output logic             rsp_deadline_miss,
   output logic [2:0]       rsp_missed_task,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   import gmts_pkg::*;

   localparam int IDXW = (TASKS > 1) ? $clog2(TASKS) : 1;
   localparam int KW = 1 + TIME_BITS + 2 + IDXW;
   localparam logic [IDXW-1:0] LAST_SHIFT = IDXW'(TASKS - 2);

   state_type state_ff, state_in;
   logic [IDXW-1:0] cnt_ff, cnt_in;
   logic [PROC_BITS-1:0] procs_ff, procs_in, procs_eff;
   logic [POLICY_BITS-1:0] policy_ff, policy_in;
   logic [CSR_DATA_BITS-1:0] wcet_ff, wcet_in, period_ff, period_in, deadline_ff, deadline_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [MASK_BITS-1:0] run_ff, run_in, run_all;
   logic miss_ff, miss_in, miss_any;
   logic [MISSED_BITS-1:0] missed_ff, missed_in, missed_idx;
   logic accept, fire;
   ctl_type ctl;
   logic [KW-1:0] probe [TASKS];
   logic [TASKS-1:0] run_bits, miss_bits;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid && !req_stall;
   assign fire = (state_ff == ST_UPDATE) && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready = 1'b1;
   assign procs_eff = (procs_ff > PROC_BITS'(TASKS)) ? PROC_BITS'(TASKS) : procs_ff;

   assign ctl.accept = accept;
   assign ctl.load = (state_ff == ST_LOAD);
   assign ctl.shift = (state_ff == ST_SHIFT);
   assign ctl.update = fire;
   assign ctl.policy = policy_ff;
   assign ctl.procs = procs_eff;

   for (genvar i = 0; i < TASKS; i++) begin : g_cell
      gmts_cell #(
         .TASKS(TASKS),
         .TIME_BITS(TIME_BITS),
         .IDX(i)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .ctl(ctl),
         .release_bit(req_release_mask[i]),
         .wcet(wcet_ff[ENTRY_BITS*i +: TIME_BITS]),
         .period(period_ff[ENTRY_BITS*i +: TIME_BITS]),
         .deadline(deadline_ff[ENTRY_BITS*i +: TIME_BITS]),
         .probe_prev(probe[(i + TASKS - 1) % TASKS]),
         .probe_next(probe[i]),
         .run_bit(run_bits[i]),
         .miss_bit(miss_bits[i])
      );
   end

   always_comb begin
      run_all = '0;
      miss_any = 1'b0;
      missed_idx = '0;
      for (int i = TASKS - 1; i >= 0; i--) begin
         run_all[i] = run_bits[i];
         if (miss_bits[i]) begin
            miss_any = 1'b1;
            missed_idx = MISSED_BITS'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cnt_in = '0;
            state_in = (TASKS > 1) ? ST_SHIFT : ST_UPDATE;
         end
         ST_SHIFT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_SHIFT) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      run_in = run_ff;
      miss_in = miss_ff;
      missed_in = missed_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         run_in = run_all;
         miss_in = miss_any;
         missed_in = missed_idx;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      procs_in = procs_ff;
      policy_in = policy_ff;
      wcet_in = wcet_ff;
      period_in = period_ff;
      deadline_in = deadline_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_PROCESSOR_COUNT: procs_in = csr_data[PROC_BITS-1:0];
            REG_POLICY:          policy_in = csr_data[POLICY_BITS-1:0];
            REG_WCET_TABLE:      wcet_in = csr_data;
            REG_PERIOD_TABLE:    period_in = csr_data;
            REG_DEADLINE_TABLE:  deadline_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         procs_ff <= PROC_BITS'(1);
         policy_ff <= POLICY_EDF;
         wcet_ff <= '0;
         period_ff <= '0;
         deadline_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         procs_ff <= procs_in;
         policy_ff <= policy_in;
         wcet_ff <= wcet_in;
         period_ff <= period_in;
         deadline_ff <= deadline_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      run_ff <= run_in;
      miss_ff <= miss_in;
      missed_ff <= missed_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_run_mask = run_ff;
   assign rsp_deadline_miss = miss_ff;
   assign rsp_missed_task = missed_ff;

endmodule
`default_nettype wire

>>> design/gmts_cell.sv
`default_nettype none
module gmts_cell #(
   parameter int TASKS = 8,
   parameter int TIME_BITS = 8,
   parameter int IDX = 0,
   localparam int IDXW = (TASKS > 1) ? $clog2(TASKS) : 1,
   localparam int KVW = TIME_BITS + 2,
   localparam int KW = 1 + KVW + IDXW
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire gmts_pkg::ctl_type     ctl,
   input  wire logic                  release_bit,
   input  wire logic [TIME_BITS-1:0]  wcet,
   input  wire logic [TIME_BITS-1:0]  period,
   input  wire logic [TIME_BITS-1:0]  deadline,
   input  wire logic [KW-1:0]         probe_prev,
   output logic      [KW-1:0]         probe_next,
   output logic                       run_bit,
   output logic                       miss_bit
);
   import gmts_pkg::*;

   localparam logic [KVW-1:0] LL_BIAS = KVW'(1) << TIME_BITS;

   logic [TIME_BITS-1:0] work_ff, work_in, timer_ff, timer_in;
   logic [TIME_BITS-1:0] work_dec, timer_dec;
   logic [KW-1:0]        key_ff, key_in, probe_ff, probe_in, key_calc;
   logic [IDXW-1:0]      rank_ff, rank_in;
   logic [TIME_BITS:0]   td_now;
   logic [KVW-1:0]       kval;
   logic                 has_work, chosen;

   function automatic logic [TIME_BITS:0] ttd_of(input logic [TIME_BITS-1:0] t,
                                                 input logic [TIME_BITS-1:0] p,
                                                 input logic [TIME_BITS-1:0] d);
      logic signed [TIME_BITS+1:0] diff;
      diff = signed'({2'b00, t}) - signed'({2'b00, p}) + signed'({2'b00, d});
      return (diff > 0) ? diff[TIME_BITS:0] : '0;
   endfunction

   assign has_work = (work_ff != '0);
   assign td_now = ttd_of(timer_ff, period, deadline);

   always_comb begin
      kval = KVW'(td_now);
      if (!has_work) begin
         kval = '0;
      end else begin
         case (ctl.policy)
            POLICY_FP: kval = '0;
            POLICY_LL: kval = KVW'(td_now) + LL_BIAS - KVW'(work_ff);
            default:   kval = KVW'(td_now);
         endcase
      end
   end

   assign key_calc = {~has_work, kval, IDXW'(IDX)};

   assign chosen = (PROC_BITS'(rank_ff) < ctl.procs);
   assign run_bit = chosen && has_work;
   assign work_dec = run_bit ? (work_ff - 1'b1) : work_ff;
   assign timer_dec = (timer_ff != '0) ? (timer_ff - 1'b1) : timer_ff;
   assign miss_bit = (ttd_of(timer_dec, period, deadline) == '0) && (work_dec != '0);

   assign probe_next = probe_ff;

   always_comb begin
      work_in = work_ff;
      timer_in = timer_ff;
      key_in = key_ff;
      probe_in = probe_ff;
      rank_in = rank_ff;
      if (ctl.accept && release_bit && (timer_ff == '0)) begin
         work_in = wcet;
         timer_in = period;
      end
      if (ctl.load) begin
         key_in = key_calc;
         probe_in = key_calc;
         rank_in = '0;
      end
      if (ctl.shift) begin
         probe_in = probe_prev;
         if (probe_prev < key_ff) begin
            rank_in = rank_ff + 1'b1;
         end
      end
      if (ctl.update) begin
         work_in = work_dec;
         timer_in = timer_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff <= '0;
         timer_ff <= '0;
      end else begin
         work_ff <= work_in;
         timer_ff <= timer_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      probe_ff <= probe_in;
      rank_ff <= rank_in;
   end

endmodule
`default_nettype wire

>>> verif/global_multiprocessor_task_scheduler_top_test.sv
`timescale 1ns / 100ps
module global_multiprocessor_task_scheduler_top_test;
   import gmts_pkg::*;

   localparam int TASK_COUNT = 8;
   localparam int WORD_CYCLES = TASK_COUNT + 2;
   localparam logic [POLICY_BITS-1:0] POLICY_SPARE = 2'd3;

   typedef struct {
      logic [MASK_BITS-1:0]   run_mask;
      logic                   deadline_miss;
      logic [MISSED_BITS-1:0] missed_task;
   } tick_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_release_mask = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_run_mask;
   logic rsp_deadline_miss;
   logic [2:0] rsp_missed_task;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [63:0] csr_data = '0;

   // scheduler copy: registers and per-task state
   logic [PROC_BITS-1:0]   cfg_procs = 4'd1;
   logic [POLICY_BITS-1:0] cfg_policy = POLICY_EDF;
   logic [63:0]            cfg_wcet = '0;
   logic [63:0]            cfg_period = '0;
   logic [63:0]            cfg_deadline = '0;
   logic [ENTRY_BITS-1:0]  work_left [TASK_COUNT];
   logic [ENTRY_BITS-1:0]  period_timer [TASK_COUNT];

   tick_result_type expected_ticks [$];
   tick_result_type want;
   int error_count = 0;
   int pattern_cycle = 0;
   int stall_mode = 0;

   global_multiprocessor_task_scheduler_top uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_release_mask(req_release_mask),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_run_mask(rsp_run_mask),
      .rsp_deadline_miss(rsp_deadline_miss),
      .rsp_missed_task(rsp_missed_task),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   initial begin
      for (int i = 0; i < TASK_COUNT; i++) begin
         work_left[i] = '0;
         period_timer[i] = '0;
      end
   end

   function automatic int table_byte(input logic [63:0] tbl, input int idx);
      return int'(tbl[8*idx +: 8]);
   endfunction

   function automatic int slack_to_deadline(input int idx);
      int v;
      v = int'(period_timer[idx])
         - (table_byte(cfg_period, idx) - table_byte(cfg_deadline, idx));
      return (v > 0) ? v : 0;
   endfunction

   function automatic bit outranks(input int a, input int b);
      bit wa;
      bit wb;
      int ka;
      int kb;
      wa = (work_left[a] != 0);
      wb = (work_left[b] != 0);
      if (!wa && !wb) return a < b;
      if (!wa || !wb) return wa;
      if (cfg_policy == POLICY_FP) return a < b;
      ka = slack_to_deadline(a);
      kb = slack_to_deadline(b);
      if (cfg_policy == POLICY_LL) begin
         ka -= int'(work_left[a]);
         kb -= int'(work_left[b]);
      end
      if (ka == kb) return a < b;
      return ka < kb;
   endfunction

   function automatic tick_result_type schedule_tick(input logic [7:0] mask);
      tick_result_type r;
      int procs;
      int rank;
      bit chosen [TASK_COUNT];
      procs = (int'(cfg_procs) > TASK_COUNT) ? TASK_COUNT : int'(cfg_procs);
      r.run_mask = '0;
      r.deadline_miss = 1'b0;
      r.missed_task = '0;
      for (int i = 0; i < TASK_COUNT; i++) begin
         if (mask[i] && period_timer[i] == 0) begin
            work_left[i] = cfg_wcet[8*i +: 8];
            period_timer[i] = cfg_period[8*i +: 8];
         end
      end
      for (int i = 0; i < TASK_COUNT; i++) begin
         rank = 0;
         for (int k = 0; k < TASK_COUNT; k++)
            if (k != i && outranks(k, i)) rank++;
         chosen[i] = (rank < procs);
      end
      for (int i = 0; i < TASK_COUNT; i++) begin
         if (chosen[i] && work_left[i] != 0) begin
            work_left[i] = work_left[i] - 1'b1;
            r.run_mask[i] = 1'b1;
         end
      end
      for (int i = 0; i < TASK_COUNT; i++) begin
         if (period_timer[i] != 0) period_timer[i] = period_timer[i] - 1'b1;
         if (slack_to_deadline(i) == 0 && work_left[i] != 0 && !r.deadline_miss) begin
            r.deadline_miss = 1'b1;
            r.missed_task = i[2:0];
         end
      end
      return r;
   endfunction

   // one tick word; entered and left just after a rising edge
   task automatic send_tick(input logic [7:0] mask);
      req_valid <= 1'b1;
      req_release_mask <= mask;
      do @(posedge clock); while (req_stall);
      expected_ticks.push_back(schedule_tick(mask));
   endtask

   task automatic wait_schedule_drained;
      while (expected_ticks.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] index, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         REG_PROCESSOR_COUNT: cfg_procs = value[PROC_BITS-1:0];
         REG_POLICY:          cfg_policy = value[POLICY_BITS-1:0];
         REG_WCET_TABLE:      cfg_wcet = value;
         REG_PERIOD_TABLE:    cfg_period = value;
         REG_DEADLINE_TABLE:  cfg_deadline = value;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [3:0] procs, input logic [1:0] pol,
                            input logic [63:0] wcet, input logic [63:0] period,
                            input logic [63:0] deadline);
      wait_schedule_drained();
      write_csr(REG_PROCESSOR_COUNT, {60'd0, procs});
      write_csr(REG_POLICY, {62'd0, pol});
      write_csr(REG_WCET_TABLE, wcet);
      write_csr(REG_PERIOD_TABLE, period);
      write_csr(REG_DEADLINE_TABLE, deadline);
      csr_valid <= 1'b0;
   endtask

   task automatic send_ticks(input logic [7:0] masks [$]);
      foreach (masks[i]) send_tick(masks[i]);
      req_valid <= 1'b0;
      wait_schedule_drained();
   endtask

   function automatic logic [7:0] random_mask;
      case ($urandom_range(0, 9))
         0: return 8'hFF;
         1: return 8'h00;
         2: return 8'h01 << $urandom_range(0, 7);
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic random_tables(output logic [63:0] wcet, output logic [63:0] period,
                                output logic [63:0] deadline);
      int p;
      int d;
      int w;
      for (int i = 0; i < TASK_COUNT; i++) begin
         p = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 16);
         d = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, p);
         w = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                          : $urandom_range(0, (d > 12 ? 12 : d) + 1);
         period[8*i +: 8] = p[7:0];
         deadline[8*i +: 8] = d[7:0];
         wcet[8*i +: 8] = w[7:0];
      end
   endtask

   task automatic test_reset_state;
      send_ticks('{8'hFF, 8'h00});
   endtask

   task automatic test_policies;
      logic [1:0] pols [4];
      pols = '{POLICY_EDF, POLICY_FP, POLICY_LL, POLICY_SPARE};
      foreach (pols[i]) begin
         configure(4'd3, pols[i], 64'h0203_0104_0203_0104, 64'h090A_060C_0807_050B,
                   64'h0608_0409_0507_030A);
         send_ticks('{8'hFF, 8'h00, 8'h00});
      end
   endtask

   task automatic test_processor_extremes;
      configure(4'd0, POLICY_EDF, 64'h0303_0303_0303_0303, 64'h0505_0505_0505_0505,
                64'h0505_0505_0505_0505);
      send_ticks('{8'hFF, 8'h00});
      configure(4'd15, POLICY_LL, 64'h0303_0303_0303_0303, 64'h0505_0505_0505_0505,
                64'h0505_0505_0505_0505);
      send_ticks('{8'h00, 8'hFF});
      configure(4'd8, POLICY_FP, 64'h0102_0304_0506_0708, 64'h0A0A_0A0A_0A0A_0A0A,
                64'h0909_0909_0909_0909);
      send_ticks('{8'h5A});
   endtask

   task automatic test_deadline_cases;
      // more work than deadline: a miss is flagged once a deadline is reached with work remaining
      configure(4'd1, POLICY_EDF, 64'h0606_0606_0606_0606, 64'h0808_0808_0808_0808,
                64'h0302_0302_0302_0302);
      send_ticks('{8'hFF, 8'h00, 8'hAA, 8'h00});
      // deadline beyond period
      configure(4'd2, POLICY_LL, 64'h0101_0101_0101_0101, 64'h0202_0202_0202_0202,
                64'h09FF_09FF_09FF_09FF);
      send_ticks('{8'h55, 8'hFF});
   endtask

   task automatic test_random_phases(input int phases, input int per_phase);
      logic [63:0] w;
      logic [63:0] p;
      logic [63:0] d;
      logic [3:0] procs;
      int sent;
      int burst;
      int gap;
      for (int ph = 0; ph < phases; ph++) begin
         random_tables(w, p, d);
         if (ph == 0) begin
            w = '1;
            p = '1;
            d = '1;
         end else if (ph == 1) begin
            w = '0;
            p = '0;
            d = '0;
         end
         case (ph % 6)
            0: procs = 4'd0;
            1: procs = 4'd15;
            2: procs = 4'd8;
            3: procs = 4'd1;
            default: procs = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                          : 4'($urandom_range(1, 8));
         endcase
         configure(procs, 2'(ph % 4), w, p, d);
         sent = 0;
         while (sent < per_phase) begin
            burst = $urandom_range(1, 16);
            for (int b = 0; b < burst && sent < per_phase; b++) begin
               send_tick(random_mask());
               sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         req_valid <= 1'b0;
         wait_schedule_drained();
      end
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      pattern_cycle <= pattern_cycle + 1;
      if (pattern_cycle % 300 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 2) == 0);
         default: rsp_stall <= ((pattern_cycle % 32) < 20);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_ticks.size() == 0) begin
            $error("result word with none expected: run_mask %h", rsp_run_mask);
            error_count++;
         end else begin
            want = expected_ticks.pop_front();
            if (rsp_run_mask !== want.run_mask) begin
               $error("run_mask expected %h actual %h", want.run_mask, rsp_run_mask);
               error_count++;
            end
            if (rsp_deadline_miss !== want.deadline_miss) begin
               $error("deadline_miss expected %b actual %b", want.deadline_miss,
                      rsp_deadline_miss);
               error_count++;
            end
            if (rsp_missed_task !== want.missed_task) begin
               $error("missed_task expected %0d actual %0d", want.missed_task,
                      rsp_missed_task);
               error_count++;
            end
         end
      end
   end

   initial begin
      int drain;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_policies();
      test_processor_extremes();
      test_deadline_cases();
      test_random_phases(19, 100);
      drain = 0;
      while (expected_ticks.size() != 0 && drain < 20000) begin
         @(posedge clock);
         drain++;
      end
      repeat (4 * WORD_CYCLES) @(posedge clock);
      if (expected_ticks.size() != 0) begin
         $error("%0d expected result words never arrived", expected_ticks.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
